/* hw/rtl/mbup_pkg.sv */
package mbup_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic CABLE_REG = 1'b0;

  localparam logic [7:0] SYSEX_OPEN  = 8'hF0;
  localparam logic [7:0] SYSEX_CLOSE = 8'hF7;
  localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;

  localparam logic [3:0] CIN_SYSCOM2    = 4'd2;
  localparam logic [3:0] CIN_SYSCOM3    = 4'd3;
  localparam logic [3:0] CIN_SYSEX_DATA = 4'd4;
  localparam logic [3:0] CIN_END1       = 4'd5;
  localparam logic [3:0] CIN_END2       = 4'd6;
  localparam logic [3:0] CIN_END3       = 4'd7;

  typedef struct packed {
    logic [3:0] cable;
    logic [3:0] cin;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } event_t;

  typedef struct packed {
    logic       known;
    logic [1:0] count;
  } msg_len_t;

  // Number of data bytes that follow a status byte.
  function automatic msg_len_t data_length(input logic [7:0] s);
    msg_len_t r;
    r.known = 1'b1;
    r.count = 2'd2;
    if (s[7:4] != SYSTEM_NIBBLE) begin
      r.count = ((s[7:4] == 4'hC) || (s[7:4] == 4'hD)) ? 2'd1 : 2'd2;
    end else begin
      case (s)
        8'hF1, 8'hF3: r.count = 2'd1;
        8'hF2: r.count = 2'd2;
        8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: r.count = 2'd0;
        default: r.known = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

/* hw/rtl/mbup_cfg.sv */
module mbup_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbup_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbup_pkg::DATA_W-1:0]  pwdata,
  output logic [mbup_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [3:0]                   cable
);
  import mbup_pkg::*;

  logic reg_hit;

  assign reg_hit = (paddr[ADDR_W-1] == CABLE_REG);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(DATA_W-4){1'b0}}, cable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cable <= 4'd0;
    end else if (psel && penable && pwrite && reg_hit) begin
      cable <= pwdata[3:0];
    end
  end

endmodule

/* hw/rtl/mbup_parser.sv */
module mbup_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       midi_byte,
  input  logic [3:0]       cable,
  output logic             ev_valid,
  output mbup_pkg::event_t ev
);
  import mbup_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_NEED1, PH_NEED2, PH_SYSEX} phase_t;

  phase_t     phase, phase_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_bytes [3];
  logic [7:0] held_bytes_next [3];
  logic [1:0] slot;
  logic       done, sysex_end, sysex_full, emit;
  logic [3:0] cin;
  msg_len_t   len;

  always_comb begin
    phase_next      = phase;
    held_count_next = held_count;
    held_bytes_next = held_bytes;
    done            = 1'b0;
    sysex_end       = 1'b0;
    len             = data_length(midi_byte);
    slot            = (held_count == 2'd3) ? 2'd0 : held_count;
    case (phase)
      PH_NEED1, PH_NEED2, PH_SYSEX: begin
        held_bytes_next[slot] = midi_byte;
        held_count_next       = held_count + 2'd1;
        if (phase == PH_NEED2) begin
          phase_next = PH_NEED1;
        end else if (phase == PH_NEED1) begin
          done = 1'b1;
        end else if (midi_byte == SYSEX_CLOSE) begin
          sysex_end = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (midi_byte[7]) begin
          held_bytes_next[0] = midi_byte;
          if (midi_byte == SYSEX_OPEN) begin
            held_count_next = 2'd1;
            phase_next      = PH_SYSEX;
          end else if (len.known) begin
            held_count_next = 2'd1;
            if (len.count == 2'd0) begin
              done = 1'b1;
            end else begin
              phase_next = (len.count == 2'd2) ? PH_NEED2 : PH_NEED1;
            end
          end
        end
      end
    endcase

    sysex_full = (phase_next == PH_SYSEX) && (held_count_next == 2'd3);
    emit       = done || sysex_end || sysex_full;

    if (done) begin
      if (held_bytes_next[0][7] && (held_bytes_next[0][7:4] != SYSTEM_NIBBLE)) begin
        cin = held_bytes_next[0][7:4];
      end else if (held_count_next == 2'd2) begin
        cin = CIN_SYSCOM2;
      end else if (held_count_next == 2'd3) begin
        cin = CIN_SYSCOM3;
      end else begin
        cin = CIN_END1;
      end
    end else if (sysex_end) begin
      cin = (held_count_next == 2'd1) ? CIN_END1 :
            (held_count_next == 2'd2) ? CIN_END2 : CIN_END3;
    end else begin
      cin = CIN_SYSEX_DATA;
    end

    ev.cable = cable;
    ev.cin   = cin;
    ev.byte0 = (held_count_next >= 2'd1) ? held_bytes_next[0] : 8'd0;
    ev.byte1 = (held_count_next >= 2'd2) ? held_bytes_next[1] : 8'd0;
    ev.byte2 = (held_count_next == 2'd3) ? held_bytes_next[2] : 8'd0;
    ev_valid = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_count <= 2'd0;
      held_bytes <= '{8'd0, 8'd0, 8'd0};
    end else if (accept) begin
      held_bytes <= held_bytes_next;
      if (emit) begin
        held_count <= 2'd0;
        phase      <= (done || sysex_end) ? PH_IDLE : phase_next;
      end else begin
        held_count <= held_count_next;
        phase      <= phase_next;
      end
    end
  end

endmodule

/* hw/rtl/mbup_out_buf.sv */
module mbup_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbup_pkg::event_t push_ev,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output mbup_pkg::event_t out_ev
);
  import mbup_pkg::*;

  logic   skid_valid;
  event_t skid_ev;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_ev     <= skid_ev;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_ev <= push_ev;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_ev    <= push_ev;
    end
  end

endmodule

/* hw/rtl/midi_byte_to_usb_event_packer.sv */
// Packs a raw MIDI byte stream into USB-MIDI event packets. One byte is taken
// in every cycle while in_stall is low; the packet that a byte completes is
// registered into the output register, or into a skid register while the sink
// stalls. Two packets can wait at the output, so in_stall rises only when both
// registers are full and the sink is stalling. Channel, system common,
// one-byte system and system exclusive messages are handled; running status is
// not. Unused event bytes are zero. The cable number is register 0 of the APB
// port and should be written only while no message is in progress.
module midi_byte_to_usb_event_packer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   midi_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   packet_cable,
  output logic [3:0]                   code_index,
  output logic [7:0]                   event_byte0,
  output logic [7:0]                   event_byte1,
  output logic [7:0]                   event_byte2,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbup_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbup_pkg::DATA_W-1:0]  pwdata,
  output logic [mbup_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import mbup_pkg::*;

  logic [3:0] cable_reg;
  logic       accept;
  logic       ev_valid;
  logic       buf_full;
  event_t     ev;
  event_t     out_ev;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  mbup_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cable   (cable_reg)
  );

  mbup_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .midi_byte (midi_byte),
    .cable     (cable_reg),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  mbup_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_valid),
    .push_ev   (ev),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev)
  );

  assign packet_cable = out_ev.cable;
  assign code_index   = out_ev.cin;
  assign event_byte0  = out_ev.byte0;
  assign event_byte1  = out_ev.byte1;
  assign event_byte2  = out_ev.byte2;

endmodule

/* hw/rtl/mbup_checker.sv */
module mbup_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] packet_cable,
  input logic [3:0] code_index,
  input logic [7:0] event_byte0,
  input logic [7:0] event_byte1,
  input logic [7:0] event_byte2
);
  import mbup_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_index) &&
      $stable(event_byte0) && $stable(event_byte1) && $stable(event_byte2) &&
      $stable(packet_cable))
    else $error("Stalled packet changed.");

  a_cin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code_index >= CIN_SYSCOM2) && (code_index != SYSTEM_NIBBLE))
    else $error("Packet carries a code index that is never produced.");

  a_channel_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_index[3] |-> event_byte0[7:4] == code_index)
    else $error("Channel packet does not start with its status byte.");

  a_short_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((code_index == CIN_END1) || (code_index == CIN_END2)) |->
      (event_byte2 == 8'd0) && ((code_index == CIN_END2) || (event_byte1 == 8'd0)))
    else $error("Short packet has nonzero unused bytes.");

endmodule

bind midi_byte_to_usb_event_packer mbup_checker u_mbup_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .packet_cable (packet_cable),
  .code_index   (code_index),
  .event_byte0  (event_byte0),
  .event_byte1  (event_byte1),
  .event_byte2  (event_byte2)
);
